// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the grid cell height filter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset
`define GCHK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included
`define GCHK_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/gchk_pkg.sv -----
// ----------------------------------------------------------------------------
// gchk_pkg
// Shared types, constants and saturation helpers of the grid cell filter.
// ----------------------------------------------------------------------------
package gchk_pkg;

  localparam int GRID_CELLS = 32;
  localparam int MAX_BATCH  = 64;
  localparam int IDX_W      = $clog2(GRID_CELLS);
  localparam int ADDR_W     = 2 * IDX_W;
  localparam int CNT_W      = $clog2(MAX_BATCH + 1);

  // Divider geometry
  localparam int DIV_NW = 64;
  localparam int DIV_DW = 40;

  localparam logic [63:0] NEAR_SQ  = 64'd429497;
  localparam logic [32:0] OFFSET_Q = 33'd327680;
  localparam logic [31:0] RCNT_MAX = 32'hFFFF_FFFF;
  localparam logic [16:0] K_MAX    = 17'h1_0000;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_MAX_RANGE      = 3'd0,
    REG_HEIGHT_CEILING = 3'd1,
    REG_CELL_SIZE      = 3'd2,
    REG_BATCH_SIZE     = 3'd3,
    REG_DECAY_GAIN     = 3'd4,
    REG_PROCESS_NOISE  = 3'd5,
    REG_MEASURE_NOISE  = 3'd6,
    REG_INITIAL_HEIGHT = 3'd7
  } cfg_reg_t;

  // One word of the per-cell store
  typedef struct packed {
    logic signed [31:0] mean;
    logic [30:0]        variance;
    logic               started;
    logic [CNT_W-1:0]   pcount;
    logic signed [37:0] psum;
    logic signed [63:0] rsum;
    logic [31:0]        rcount;
  } cell_t;

  // Divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sd2147483647)       r = 32'sh7FFF_FFFF;
    else if (v < -64'sd2147483648) r = 32'sh8000_0000;
    else                           r = v[31:0];
    return r;
  endfunction

  function automatic logic [30:0] satv(input logic [63:0] v);
    logic [30:0] r;
    if (v > 64'd2147483647) r = 31'h7FFF_FFFF;
    else                    r = v[30:0];
    return r;
  endfunction

endpackage

// ----- sv/gchk_div.sv -----
// ----------------------------------------------------------------------------
// gchk_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gchk_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [gchk_pkg::DIV_NW-1:0]  dividend,
  input  logic [gchk_pkg::DIV_DW-1:0]  divisor,
  output logic [gchk_pkg::DIV_NW-1:0]  quot,
  output gchk_pkg::div_stat_t          stat
);
  import gchk_pkg::*;

  localparam int STEP_W = $clog2(DIV_NW + 1);

  logic [DIV_DW-1:0] rem_r;
  logic [DIV_DW-1:0] dsr_r;
  logic [DIV_NW-1:0] quo_r;
  logic [STEP_W-1:0] step_r;
  logic              busy_r;
  logic              done_r;
  logic [DIV_DW:0]   rem_sh;
  logic [DIV_DW+1:0] trial;

  // trial subtract of the shifted remainder
  assign rem_sh = {rem_r, quo_r[DIV_NW-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      // done pulses for one cycle after the last step
      done_r <= !start && busy_r && (step_r == STEP_W'(1));
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(DIV_NW);
        rem_r  <= '0;
        dsr_r  <= divisor;
        quo_r  <= dividend;
      end else if (busy_r) begin
        if (!trial[DIV_DW+1]) begin
          rem_r <= trial[DIV_DW-1:0];
          quo_r <= {quo_r[DIV_NW-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh[DIV_DW-1:0];
          quo_r <= {quo_r[DIV_NW-2:0], 1'b0};
        end
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign quot      = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ----- sv/grid_cell_height_kalman.sv -----
// ----------------------------------------------------------------------------
// grid_cell_height_kalman
// Point filter, grid binning and per-cell scalar Kalman height update.
// ----------------------------------------------------------------------------
// After reset the block sweeps its 1024-entry cell store to zero, one entry a
// cycle, and takes no point during the sweep (config writes are taken).
// Then it handles one point at a time, taking no new point until the last
// is dropped by the near, range, height or grid tests, joins a cell batch,
// or completes a batch and has its result in the output register, where it
// waits while the next point is taken. The pace is set by the single 64-step
// restoring divider, used for both bin indexes, the Kalman gain and the
// long-run mean, and by the one shared 33x33 multiplier.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module grid_cell_height_kalman (
  input  logic                clk,
  input  logic                rst_n,
  // config write
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  // point in
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  in_sensor_x,
  input  logic signed [31:0]  in_sensor_y,
  input  logic signed [31:0]  in_base_x,
  input  logic signed [31:0]  in_base_y,
  input  logic signed [31:0]  in_base_z,
  input  logic signed [31:0]  in_world_x,
  input  logic signed [31:0]  in_world_y,
  input  logic signed [31:0]  in_world_z,
  // cell update out
  output logic                out_valid,
  input  logic                out_ready,
  output logic [gchk_pkg::IDX_W-1:0] out_cell_row,
  output logic [gchk_pkg::IDX_W-1:0] out_cell_col,
  output logic signed [31:0]  out_height_estimate,
  output logic [30:0]         out_height_variance,
  output logic [30:0]         out_height_dev
);
  import gchk_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_NEAR1, S_NEAR2, S_NEAR3, S_RNG1, S_RNG2, S_RNG3,
    S_BINX, S_BINY, S_RD, S_ACC, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6,
    S_KDIV, S_M1, S_M2, S_M3, S_M4, S_REF, S_EMIT
  } state_t;

  state_t state_r;

  // configuration
  logic [30:0]        max_range_r, cell_size_r, proc_noise_r, meas_noise_r;
  logic signed [31:0] ceiling_r, decay_r, init_h_r;
  logic [6:0]         batch_r;

  // latched point
  logic signed [31:0] sx_r, sy_r, bx_r, by_r, bz_r, wx_r, wy_r, wz_r;

  // working registers
  logic [63:0]           acc_r;
  logic [IDX_W-1:0]      row_r, col_r;
  logic [ADDR_W-1:0]     clr_r;
  cell_t                 ent_r;
  logic signed [31:0]    mp_r;
  logic [30:0]           vp_r;
  logic signed [39:0]    innov_r;
  logic [16:0]           k_r;
  logic signed [63:0]    pacc_r;
  logic signed [31:0]    mean_r;
  logic [30:0]           var_r;
  logic [30:0]           err_r;

  // output register
  logic                  out_valid_r;
  logic [IDX_W-1:0]      o_row_r, o_col_r;
  logic signed [31:0]    o_est_r;
  logic [30:0]           o_var_r, o_err_r;

  // shared multiplier
  logic signed [32:0]    mul_a, mul_b;
  logic signed [65:0]    mul_r;

  // shared divider
  logic                  div_start;
  logic [DIV_NW-1:0]     div_n;
  logic [DIV_DW-1:0]     div_d;
  logic [DIV_NW-1:0]     div_q;
  div_stat_t             div_stat;

  // cell store
  cell_t                 mem [2**ADDR_W];
  cell_t                 rd_r;
  logic                  mem_we;
  logic [ADDR_W-1:0]     mem_wa;
  cell_t                 mem_wd;

  // derived values
  logic [30:0]        cs_eff, q_eff;
  logic [CNT_W-1:0]   eb;
  logic [31:0]        a_abs;
  logic signed [32:0] xw, yw;
  logic [63:0]        d2_sum;
  logic signed [31:0] m_prior;
  logic [30:0]        t1, t2, vp;
  logic [31:0]        t2_sum;
  logic [39:0]        den;
  logic signed [63:0] prod, mean_wide;
  logic [63:0]        rsum_abs;
  logic signed [32:0] ref_s;
  logic signed [33:0] err_d;
  logic [33:0]        err_abs;
  cell_t              upd;
  logic               upd_add, upd_full;

  gchk_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .quot     (div_q),
    .stat     (div_stat)
  );

  // register corner cases
  assign cs_eff = (cell_size_r == '0) ? 31'd1 : cell_size_r;
  assign q_eff  = (meas_noise_r == '0) ? 31'd1 : meas_noise_r;
  always_comb begin
    if (batch_r == '0)                  eb = CNT_W'(1);
    else if (batch_r > 7'(MAX_BATCH))   eb = CNT_W'(MAX_BATCH);
    else                                eb = CNT_W'(batch_r);
  end
  assign a_abs = decay_r[31] ? 32'(-decay_r) : 32'(decay_r);

  // offset world coordinates
  assign xw = 33'(wx_r) + $signed(OFFSET_Q);
  assign yw = 33'(wy_r) + $signed(OFFSET_Q);
  assign d2_sum = acc_r + 64'(mul_r[63:0]);

  // prediction terms
  assign m_prior = ent_r.started ? ent_r.mean : init_h_r;
  assign t1      = satv(64'(mul_r[63:0] >> 16));
  assign t2      = satv(64'(mul_r[63:0] >> 16));
  assign t2_sum  = {1'b0, t2} + {1'b0, proc_noise_r};
  assign vp      = satv(64'(t2_sum));
  assign den     = 40'(q_eff) + mul_r[39:0];

  // mean correction
  assign prod      = pacc_r + $signed(mul_r[63:0]);
  assign mean_wide = 64'(mp_r) + (prod >>> 16);
  assign rsum_abs  = ent_r.rsum[63] ? 64'(-ent_r.rsum) : 64'(ent_r.rsum);

  // long-run mean and error
  always_comb begin
    if (ent_r.rcount == '0)  ref_s = '0;
    else if (ent_r.rsum[63]) ref_s = -$signed({1'b0, div_q[31:0]});
    else                     ref_s = $signed({1'b0, div_q[31:0]});
  end
  assign err_d   = 34'(mean_r) - 34'(ref_s);
  assign err_abs = err_d[33] ? 34'(-err_d) : 34'(err_d);

  // batch accumulation of the fetched cell
  always_comb begin
    upd     = rd_r;
    upd_add = rd_r.pcount < eb;
    if (upd_add) begin
      upd.pcount = rd_r.pcount + 1'b1;
      upd.psum   = rd_r.psum + 38'(wz_r);
      if (rd_r.rcount != RCNT_MAX) begin
        upd.rcount = rd_r.rcount + 1'b1;
        upd.rsum   = rd_r.rsum + 64'(wz_r);
      end
    end
    upd_full = !upd_add || (upd.pcount == eb);
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_NEAR1: begin mul_a = 33'(sx_r); mul_b = 33'(sx_r); end
      S_NEAR2: begin mul_a = 33'(sy_r); mul_b = 33'(sy_r); end
      S_NEAR3: begin mul_a = 33'(bx_r); mul_b = 33'(bx_r); end
      S_RNG1:  begin mul_a = 33'(by_r); mul_b = 33'(by_r); end
      S_RNG2:  begin mul_a = {2'b00, max_range_r}; mul_b = {2'b00, max_range_r}; end
      S_P1:    begin mul_a = 33'(m_prior); mul_b = 33'(decay_r); end
      S_P2:    begin mul_a = {2'b00, ent_r.variance}; mul_b = {1'b0, a_abs}; end
      S_P3:    begin mul_a = {2'b00, t1}; mul_b = {1'b0, a_abs}; end
      S_P4:    begin mul_a = 33'({1'b0, ent_r.pcount}); mul_b = {2'b00, vp}; end
      S_P5:    begin mul_a = 33'({1'b0, ent_r.pcount}); mul_b = 33'(mp_r); end
      S_M1:    begin mul_a = 33'($signed(innov_r[39:20])); mul_b = {16'd0, k_r}; end
      S_M2:    begin mul_a = {13'd0, innov_r[19:0]}; mul_b = {16'd0, k_r}; end
      S_M3:    begin mul_a = {2'b00, q_eff}; mul_b = {16'd0, k_r}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
  end

  // divider operand select and start
  always_comb begin
    div_start = 1'b0;
    div_n     = '0;
    div_d     = '0;
    case (state_r)
      S_RNG3: begin
        div_start = !(acc_r > 64'(mul_r[63:0])) && !(bz_r > ceiling_r) &&
                    (xw > 0) && (yw > 0);
        div_n     = 64'(xw - 33'sd1);
        div_d     = 40'(cs_eff);
      end
      S_BINX: begin
        div_start = div_stat.done && (div_q < 64'(GRID_CELLS));
        div_n     = 64'(yw - 33'sd1);
        div_d     = 40'(cs_eff);
      end
      S_P5: begin
        div_start = 1'b1;
        div_n     = {17'd0, vp_r, 16'd0};
        div_d     = den;
      end
      S_M3: begin
        div_start = ent_r.rcount != '0;
        div_n     = rsum_abs;
        div_d     = 40'(ent_r.rcount);
      end
      default: ;
    endcase
  end

  // cell store write select
  always_comb begin
    mem_we = 1'b0;
    mem_wa = {row_r, col_r};
    mem_wd = upd;
    case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_r;
        mem_wd = '0;
      end
      S_ACC: mem_we = !upd_full;
      S_M4: begin
        mem_we          = 1'b1;
        mem_wd          = ent_r;
        mem_wd.mean     = mean_r;
        mem_wd.variance = satv(64'(mul_r[63:0] >> 16));
        mem_wd.started  = 1'b1;
        mem_wd.pcount   = '0;
        mem_wd.psum     = '0;
      end
      default: ;
    endcase
  end

  // cell store
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_r <= mem[{row_r, col_r}];
  end

  // configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_range_r  <= 31'd327680;
      ceiling_r    <= 32'sd36045;
      cell_size_r  <= 31'd20480;
      batch_r      <= 7'd10;
      decay_r      <= 32'sd65536;
      proc_noise_r <= 31'd65536;
      meas_noise_r <= 31'd65536;
      init_h_r     <= 32'sd32768;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MAX_RANGE:      max_range_r  <= cfg_data[30:0];
        REG_HEIGHT_CEILING: ceiling_r    <= cfg_data;
        REG_CELL_SIZE:      cell_size_r  <= cfg_data[30:0];
        REG_BATCH_SIZE:     batch_r      <= cfg_data[6:0];
        REG_DECAY_GAIN:     decay_r      <= cfg_data;
        REG_PROCESS_NOISE:  proc_noise_r <= cfg_data[30:0];
        REG_MEASURE_NOISE:  meas_noise_r <= cfg_data[30:0];
        REG_INITIAL_HEIGHT: init_h_r     <= cfg_data;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_EMIT) out_valid_r <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == '1) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            sx_r <= in_sensor_x; sy_r <= in_sensor_y;
            bx_r <= in_base_x;   by_r <= in_base_y;   bz_r <= in_base_z;
            wx_r <= in_world_x;  wy_r <= in_world_y;  wz_r <= in_world_z;
            state_r <= S_NEAR1;
          end
        end
        S_NEAR1: state_r <= S_NEAR2;
        S_NEAR2: begin
          acc_r   <= mul_r[63:0];
          state_r <= S_NEAR3;
        end
        S_NEAR3: begin
          if (d2_sum < NEAR_SQ) state_r <= S_IDLE;
          else                  state_r <= S_RNG1;
        end
        S_RNG1: begin
          acc_r   <= mul_r[63:0];
          state_r <= S_RNG2;
        end
        S_RNG2: begin
          acc_r   <= d2_sum;
          state_r <= S_RNG3;
        end
        S_RNG3: state_r <= div_start ? S_BINX : S_IDLE;
        S_BINX: begin
          if (div_stat.done) begin
            row_r   <= div_q[IDX_W-1:0];
            state_r <= div_start ? S_BINY : S_IDLE;
          end
        end
        S_BINY: begin
          if (div_stat.done) begin
            col_r   <= div_q[IDX_W-1:0];
            state_r <= (div_q < 64'(GRID_CELLS)) ? S_RD : S_IDLE;
          end
        end
        S_RD: state_r <= S_ACC;
        S_ACC: begin
          ent_r   <= upd;
          state_r <= upd_full ? S_P1 : S_IDLE;
        end
        S_P1: state_r <= S_P2;
        S_P2: begin
          mp_r    <= sat32($signed(mul_r[63:0]) >>> 16);
          state_r <= S_P3;
        end
        S_P3: state_r <= S_P4;
        S_P4: begin
          vp_r    <= vp;
          state_r <= S_P5;
        end
        S_P5: state_r <= S_P6;
        S_P6: begin
          innov_r <= 40'(ent_r.psum) - $signed(mul_r[39:0]);
          state_r <= S_KDIV;
        end
        S_KDIV: begin
          if (div_stat.done) begin
            k_r     <= div_q[16:0];
            state_r <= S_M1;
          end
        end
        S_M1: state_r <= S_M2;
        S_M2: begin
          pacc_r  <= $signed(mul_r[63:0]) <<< 20;
          state_r <= S_M3;
        end
        S_M3: begin
          mean_r  <= sat32(mean_wide);
          state_r <= S_M4;
        end
        S_M4: begin
          var_r   <= satv(64'(mul_r[63:0] >> 16));
          state_r <= S_REF;
        end
        S_REF: begin
          if (div_stat.done || ent_r.rcount == '0) begin
            err_r   <= satv(64'(err_abs));
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            o_row_r     <= row_r;
            o_col_r     <= col_r;
            o_est_r     <= mean_r;
            o_var_r     <= var_r;
            o_err_r     <= err_r;
            state_r     <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign in_ready            = (state_r == S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_cell_row        = o_row_r;
  assign out_cell_col        = o_col_r;
  assign out_height_estimate = o_est_r;
  assign out_height_variance = o_var_r;
  assign out_height_dev      = o_err_r;

  // checks
  `GCHK_ASSERT(a_div_idle_start, div_start |-> !div_stat.busy, "divider restarted while busy")
  `GCHK_ASSERT(a_gain_bound, (state_r == S_M1) |-> (k_r <= K_MAX), "gain above one")
  `GCHK_ASSERT(a_out_from_emit, $rose(out_valid_r) |-> $past(state_r == S_EMIT), "stray result")
  `GCHK_ASSERT_RST(a_reset_quiet, !rst_n |=> (!out_valid_r && !in_ready), "active after reset")

endmodule

// ----- tb/sv/grid_cell_height_checker.sv -----
// ----------------------------------------------------------------------------
// grid_cell_height_checker
// Watches the config, point and cell update channels of the grid cell height
// filter. Every accepted point goes through a local model of the point
// filter, the binning and the per-cell Kalman step. Any cell update it causes
// is queued and compared field by field with the next word out of the block.
// ----------------------------------------------------------------------------
module grid_cell_height_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] in_sensor_x,
  input  logic signed [31:0] in_sensor_y,
  input  logic signed [31:0] in_base_x,
  input  logic signed [31:0] in_base_y,
  input  logic signed [31:0] in_base_z,
  input  logic signed [31:0] in_world_x,
  input  logic signed [31:0] in_world_y,
  input  logic signed [31:0] in_world_z,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [4:0]         out_cell_row,
  input  logic [4:0]         out_cell_col,
  input  logic signed [31:0] out_height_estimate,
  input  logic [30:0]        out_height_variance,
  input  logic [30:0]        out_height_dev,
  output int                 mismatches,
  output int                 updates_due
);
  timeunit 1ns;
  timeprecision 1ps;
  import gchk_pkg::*;

  localparam int NCELLS = GRID_CELLS * GRID_CELLS;

  typedef struct packed {
    logic [4:0]         row;
    logic [4:0]         col;
    logic signed [31:0] estimate;
    logic [30:0]        variance;
    logic [30:0]        error;
  } cell_update_t;

  // config mirror
  longint range_lim, ceiling, cell_edge, batch, decay, proc_noise, meas_noise, prior;

  // per-cell filter state
  longint cell_est[NCELLS];
  longint cell_var[NCELLS];
  bit     cell_live[NCELLS];
  longint batch_cnt[NCELLS];
  longint batch_sum[NCELLS];
  longint hist_sum[NCELLS];
  longint hist_cnt[NCELLS];

  cell_update_t updates_q[$];
  int           fail_cnt = 0;

  function automatic longint clip_s32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clip_u31(input longint v);
    return (v > 64'sd2147483647) ? 64'sd2147483647 : v;
  endfunction

  function automatic longint div_up(input longint x, input longint d);
    if (x > 0) return (x + d - 1) / d;
    return -((-x) / d);
  endfunction

  // Point filter, binning and Kalman step; returns 1 when a cell update results
  function automatic bit cell_kalman_step(input longint sx, sy, bx, by, bz, wx, wy, wz,
                                          output cell_update_t upd);
    longint unsigned d2, r2;
    longint cs, row, col, eb, n, m, mp, a_abs, t1, t2, vp, q, den, k, innov, est, avg;
    int idx;
    upd = '0;
    d2 = longint'(sx * sx) + longint'(sy * sy);
    if (d2 < 64'd429497) return 0;
    d2 = longint'(bx * bx) + longint'(by * by);
    r2 = longint'(range_lim * range_lim);
    if (d2 > r2) return 0;
    if (bz > ceiling) return 0;
    cs  = (cell_edge == 0) ? 1 : cell_edge;
    row = div_up(wx + 327680, cs) - 1;
    col = div_up(wy + 327680, cs) - 1;
    if (row < 0 || row >= GRID_CELLS || col < 0 || col >= GRID_CELLS) return 0;
    idx = int'(row * GRID_CELLS + col);
    eb  = (batch < 1) ? 1 : ((batch > MAX_BATCH) ? MAX_BATCH : batch);
    // a cell already at or past a shrunk batch drops the point and updates now
    if (batch_cnt[idx] < eb) begin
      batch_cnt[idx]++;
      batch_sum[idx] += wz;
      if (hist_cnt[idx] < 64'sd4294967295) begin
        hist_cnt[idx]++;
        hist_sum[idx] += wz;
      end
      if (batch_cnt[idx] < eb) return 0;
    end
    n     = batch_cnt[idx];
    m     = cell_live[idx] ? cell_est[idx] : prior;
    mp    = clip_s32((m * decay) >>> 16);
    a_abs = (decay < 0) ? -decay : decay;
    t1    = clip_u31((cell_var[idx] * a_abs) >>> 16);
    t2    = clip_u31((t1 * a_abs) >>> 16);
    vp    = clip_u31(t2 + proc_noise);
    q     = (meas_noise == 0) ? 1 : meas_noise;
    den   = q + n * vp;
    k     = (vp <<< 16) / den;
    innov = batch_sum[idx] - n * mp;
    est   = clip_s32(mp + ((innov * k) >>> 16));
    cell_est[idx]  = est;
    cell_var[idx]  = clip_u31((q * k) >>> 16);
    cell_live[idx] = 1;
    batch_cnt[idx] = 0;
    batch_sum[idx] = 0;
    avg = (hist_cnt[idx] != 0) ? hist_sum[idx] / hist_cnt[idx] : 0;
    avg = est - avg;
    if (avg < 0) avg = -avg;
    upd.row      = row[4:0];
    upd.col      = col[4:0];
    upd.estimate = est[31:0];
    upd.variance = cell_var[idx][30:0];
    upd.error    = 31'(clip_u31(avg));
    return 1;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    fail_cnt++;
  endtask

  always @(posedge clk) begin
    cell_update_t upd, want;
    if (!rst_n) begin
      range_lim  = 327680;
      ceiling    = 36045;
      cell_edge  = 20480;
      batch      = 10;
      decay      = 65536;
      proc_noise = 65536;
      meas_noise = 65536;
      prior      = 32768;
      for (int i = 0; i < NCELLS; i++) begin
        cell_est[i]  = 0;
        cell_var[i]  = 0;
        cell_live[i] = 0;
        batch_cnt[i] = 0;
        batch_sum[i] = 0;
        hist_sum[i]  = 0;
        hist_cnt[i]  = 0;
      end
      updates_q.delete();
    end else begin
      // config word
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_MAX_RANGE:      range_lim  = longint'(cfg_data[30:0]);
          REG_HEIGHT_CEILING: ceiling    = longint'($signed(cfg_data));
          REG_CELL_SIZE:      cell_edge  = longint'(cfg_data[30:0]);
          REG_BATCH_SIZE:     batch      = longint'(cfg_data[6:0]);
          REG_DECAY_GAIN:     decay      = longint'($signed(cfg_data));
          REG_PROCESS_NOISE:  proc_noise = longint'(cfg_data[30:0]);
          REG_MEASURE_NOISE:  meas_noise = longint'(cfg_data[30:0]);
          REG_INITIAL_HEIGHT: prior      = longint'($signed(cfg_data));
          default: ;
        endcase
      end
      // point word
      if (in_valid && in_ready) begin
        if (cell_kalman_step(in_sensor_x, in_sensor_y, in_base_x, in_base_y, in_base_z,
                             in_world_x, in_world_y, in_world_z, upd))
          updates_q.insert(updates_q.size(), upd);
      end
      // cell update word
      if (out_valid && out_ready) begin
        if (updates_q.size() == 0) begin
          report_mismatch("unexpected update, row", out_cell_row, -1);
        end else begin
          want = updates_q.pop_front();
          if (out_cell_row != want.row)
            report_mismatch("cell_row", out_cell_row, want.row);
          if (out_cell_col != want.col)
            report_mismatch("cell_col", out_cell_col, want.col);
          if (out_height_estimate != want.estimate)
            report_mismatch("height_estimate", out_height_estimate, want.estimate);
          if (out_height_variance != want.variance)
            report_mismatch("height_variance", out_height_variance, want.variance);
          if (out_height_dev != want.error)
            report_mismatch("height_dev", out_height_dev, want.error);
        end
      end
    end
    updates_due <= updates_q.size();
    mismatches  <= fail_cnt;
  end

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the grid cell height filter. Directed points hit
// the drop tests, the grid edges and a shrunk batch; then random phases run
// at several config settings, extremes included, with random gaps on both
// channels, one long output hold-off and full-rate stretches.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import gchk_pkg::*;

  logic               clk = 0;
  logic               rst_n;
  logic               cfg_valid, cfg_ready;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;
  logic               in_valid, in_ready;
  logic signed [31:0] in_sensor_x, in_sensor_y, in_base_x, in_base_y, in_base_z;
  logic signed [31:0] in_world_x, in_world_y, in_world_z;
  logic               out_valid, out_ready;
  logic [4:0]         out_cell_row, out_cell_col;
  logic signed [31:0] out_height_estimate;
  logic [30:0]        out_height_variance, out_height_dev;
  int                 mismatches, updates_due;

  // settings the point generator aims at
  longint range_now = 327680, ceiling_now = 36045, edge_now = 20480;
  bit     gaps_on = 1;
  bit     hold_long = 0;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  grid_cell_height_kalman i_dut (.*);

  grid_cell_height_checker i_checker (.*);

  initial begin
    #40_000_000;
    $display("Some tests failed");
    $finish;
  end

  // result sink: random stalls, one long hold-off on request
  initial begin
    out_ready = 0;
    forever begin
      if (hold_long) begin
        out_ready <= 0;
        repeat (3000) @(posedge clk);
        hold_long = 0;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      out_ready <= 1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    @(posedge clk);
    case (idx)
      REG_MAX_RANGE:      range_now   = longint'(val[30:0]);
      REG_HEIGHT_CEILING: ceiling_now = longint'($signed(val));
      REG_CELL_SIZE:      edge_now    = longint'(val[30:0]);
      default: ;
    endcase
  endtask

  task automatic send_point(input int sx, sy, bx, by, bz, wx, wy, wz);
    in_valid    <= 1;
    in_sensor_x <= sx;
    in_sensor_y <= sy;
    in_base_x   <= bx;
    in_base_y   <= by;
    in_base_z   <= bz;
    in_world_x  <= wx;
    in_world_y  <= wy;
    in_world_z  <= wz;
    do @(posedge clk); while (!in_ready);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // wait for every update, then cover a point that is still being binned
  task automatic drain;
    in_valid <= 0;
    do @(posedge clk); while (updates_due != 0);
    repeat (400) @(posedge clk);
  endtask

  // world coordinate landing in grid index idx for the current cell edge
  function automatic int aim_world(input int idx);
    longint cs, v;
    cs = (edge_now == 0) ? 1 : edge_now;
    v  = idx * cs - 327680 + longint'($urandom_range(1, int'(cs)));
    if (v > 64'sd2147483647 || v < -64'sd2147483648)
      v = -327680 + longint'($urandom_range(1, int'(cs)));
    return int'(v);
  endfunction

  // point passing all drop tests, aimed at cell (row, col)
  task automatic good_point(input int row, col);
    longint lim, bx, by, bz;
    int sx, wz;
    lim = range_now >> 1;
    bx  = (lim == 0) ? 0 : longint'($urandom_range(0, int'(lim * 2))) - lim;
    by  = (lim == 0) ? 0 : longint'($urandom_range(0, int'(lim * 2))) - lim;
    bz  = ceiling_now - longint'($urandom_range(0, 200000));
    if (bz < -64'sd2147483648) bz = ceiling_now;
    sx  = $urandom_range(656, 1 << 20);
    if ($urandom_range(0, 1)) sx = -sx;
    wz  = ($urandom_range(0, 3) == 0) ? $urandom : int'($urandom_range(0, 1 << 19)) - (1 << 18);
    send_point(sx, $urandom_range(0, 1 << 12), int'(bx), int'(by), int'(bz),
               aim_world(row), aim_world(col), wz);
  endtask

  task automatic random_points(input int count);
    int row, col;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 6) == 0) begin
        send_point($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom);
      end else begin
        row = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 3);
        col = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 3);
        good_point(row, col);
      end
    end
  endtask

  initial begin
    rst_n       = 0;
    cfg_valid   = 0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_valid    = 0;
    in_sensor_x = '0;
    in_sensor_y = '0;
    in_base_x   = '0;
    in_base_y   = '0;
    in_base_z   = '0;
    in_world_x  = '0;
    in_world_y  = '0;
    in_world_z  = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1;

    // near test: zero, just inside, just outside
    send_point(0, 0, 0, 0, 0, 0, 0, 1000);
    send_point(655, 0, 0, 0, 0, 0, 0, 1000);
    send_point(656, 0, 0, 0, 0, 0, 0, 2000);
    // range test on the limit and one past
    send_point(65536, 0, 327680, 0, 0, 0, 0, 3000);
    send_point(65536, 0, 327681, 0, 0, 0, 0, 3000);
    // height ceiling on the limit and one past
    send_point(65536, 0, 0, 0, 36045, 0, 0, 4000);
    send_point(65536, 0, 0, 0, 36046, 0, 0, 4000);
    // grid edges
    send_point(65536, 0, 0, 0, 0, -327680, 0, 5000);
    send_point(65536, 0, 0, 0, 0, -327679, -327679, 5000);
    send_point(65536, 0, 0, 0, 0, 327680, 327680, 6000);
    send_point(65536, 0, 0, 0, 0, 327681, 0, 6000);
    // field extremes
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(65536, 0, 0, 0, 32'h8000_0000, 0, 0, 32'h7FFF_FFFF);
    // shrunk batch: four pending, batch cut to two, next point updates at once
    repeat (4) good_point(5, 5);
    drain();
    write_reg(REG_BATCH_SIZE, 32'd2);
    good_point(5, 5);
    repeat (2) good_point(5, 5);
    repeat (2) good_point(0, 0);
    drain();

    // batch of one, so every kept point updates; extremes; long output hold-off fills the block
    write_reg(REG_MAX_RANGE, 32'h7FFF_FFFF);
    write_reg(REG_HEIGHT_CEILING, 32'h7FFF_FFFF);
    write_reg(REG_CELL_SIZE, 32'd0);
    write_reg(REG_BATCH_SIZE, 32'd1);
    write_reg(REG_DECAY_GAIN, 32'h7FFF_FFFF);
    write_reg(REG_PROCESS_NOISE, 32'h7FFF_FFFF);
    write_reg(REG_MEASURE_NOISE, 32'd0);
    write_reg(REG_INITIAL_HEIGHT, 32'h8000_0000);
    hold_long = 1;
    random_points(30);
    drain();
    random_points(220);
    drain();

    // opposite extremes, largest batch and cell
    write_reg(REG_MAX_RANGE, 32'd0);
    write_reg(REG_HEIGHT_CEILING, 32'h8000_0000);
    write_reg(REG_CELL_SIZE, 32'h7FFF_FFFF);
    write_reg(REG_BATCH_SIZE, 32'd64);
    write_reg(REG_DECAY_GAIN, 32'h8000_0000);
    write_reg(REG_PROCESS_NOISE, 32'd0);
    write_reg(REG_MEASURE_NOISE, 32'h7FFF_FFFF);
    write_reg(REG_INITIAL_HEIGHT, 32'h7FFF_FFFF);
    random_points(130);
    drain();

    // batch above the maximum, small cells, no gaps
    gaps_on = 0;
    write_reg(REG_MAX_RANGE, 32'd655360);
    write_reg(REG_HEIGHT_CEILING, 32'd131072);
    write_reg(REG_CELL_SIZE, 32'd8192);
    write_reg(REG_BATCH_SIZE, 32'd127);
    write_reg(REG_DECAY_GAIN, 32'hFFFF_0000);
    write_reg(REG_MEASURE_NOISE, 32'd1);
    random_points(140);
    drain();
    gaps_on = 1;

    // random moderate settings, batch zero among them
    for (int p = 0; p < 3; p++) begin
      if (p == 2) gaps_on = 0;
      write_reg(REG_MAX_RANGE, $urandom_range(100000, 1 << 22));
      write_reg(REG_HEIGHT_CEILING, int'($urandom_range(0, 1 << 20)) - (1 << 19));
      write_reg(REG_CELL_SIZE, $urandom_range(8192, 40000));
      write_reg(REG_BATCH_SIZE, (p == 0) ? 32'd0 : $urandom_range(1, 12));
      write_reg(REG_DECAY_GAIN, int'($urandom_range(0, 1 << 18)) - (1 << 17));
      write_reg(REG_PROCESS_NOISE, $urandom_range(0, 1 << 20));
      write_reg(REG_MEASURE_NOISE, $urandom_range(1, 1 << 20));
      write_reg(REG_INITIAL_HEIGHT, $urandom);
      random_points(300);
      drain();
    end

    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
